[rtl/assert_macros.svh]
// assertion macros included by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/anp_pkg.sv]
// shared constants and controller/datapath interface types for the path normaliser
package anp_pkg;

   localparam int PATH_BYTES  = 64;
   localparam int IDX_W       = $clog2(PATH_BYTES);
   localparam int POS_W       = IDX_W + 1;
   localparam int STACK_SLOTS = PATH_BYTES / 2;
   localparam int SLOT_W      = $clog2(STACK_SLOTS);
   localparam int DEPTH_W     = SLOT_W + 1;
   localparam int SIZE_W      = 7;
   localparam int SEEN_W      = 7;
   localparam int BYTE_W      = 8;

   localparam logic [SEEN_W-1:0] SEEN_MAX   = '1;
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(PATH_BYTES);

   localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_INVALID   = 2'd1,
      STATUS_TOO_SMALL = 2'd2
   } status_type;

   typedef struct packed {
      logic load;
      logic first;
      logic mark_end;
      logic count;
      logic open_comp;
      logic put_char;
      logic close;
      logic pop2;
      logic emit_error;
      logic drain_start;
      logic drain_step;
      logic clear;
   } dp_cmd_type;

   typedef struct packed {
      logic active;
      logic first;
      logic is_zero;
      logic is_slash;
      logic full_after;
      logic open_empty;
      logic pop2_needed;
      logic last_beat;
      logic fail;
      logic out_free;
      logic drain_last;
   } dp_stat_type;

endpackage

[rtl/anp_ram.sv]
// generic single-write, single-read ram with registered read data
module anp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/anp_ctrl.sv]
// controller state machine sequencing absorb, close, pop, emit and drain steps
module anp_ctrl
   import anp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_BYTE  = 7'b0000010,
      ST_CHAR  = 7'b0000100,
      ST_CLOSE = 7'b0001000,
      ST_POP2  = 7'b0010000,
      ST_EMIT  = 7'b0100000,
      ST_DRAIN = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   state_type resume_state;

   always_comb begin
      resume_state = stat.last_beat ? ST_EMIT : ST_IDLE;
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_BYTE;
            end
         end
         ST_BYTE: begin
            priority if (!stat.active) begin
               state_in = resume_state;
            end else if (stat.first) begin
               cmd.first = 1'b1;
               state_in  = resume_state;
            end else if (stat.is_zero) begin
               cmd.mark_end = 1'b1;
               state_in     = ST_CLOSE;
            end else begin
               cmd.count = 1'b1;
               priority if (stat.full_after) begin
                  state_in = resume_state;
               end else if (stat.is_slash) begin
                  state_in = ST_CLOSE;
               end else if (stat.open_empty) begin
                  cmd.open_comp = 1'b1;
                  state_in      = ST_CHAR;
               end else begin
                  cmd.put_char = 1'b1;
                  state_in     = stat.last_beat ? ST_CLOSE : ST_IDLE;
               end
            end
         end
         ST_CHAR: begin
            cmd.put_char = 1'b1;
            state_in     = stat.last_beat ? ST_CLOSE : ST_IDLE;
         end
         ST_CLOSE: begin
            cmd.close = 1'b1;
            state_in  = stat.pop2_needed ? ST_POP2 : resume_state;
         end
         ST_POP2: begin
            cmd.pop2 = 1'b1;
            state_in = resume_state;
         end
         ST_EMIT: begin
            if (stat.fail) begin
               if (stat.out_free) begin
                  cmd.emit_error = 1'b1;
                  cmd.clear      = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else begin
               cmd.drain_start = 1'b1;
               state_in        = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (stat.out_free) begin
               cmd.drain_step = 1'b1;
               if (stat.drain_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

[rtl/anp_datapath.sv]
// datapath: path buffer ram, separator stack, counters and rsp output register
module anp_datapath
   import anp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [BYTE_W-1:0] req_tdata,
   input  logic              req_tlast,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data,
   input  dp_cmd_type        cmd,
   output dp_stat_type       stat,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast
);

   logic [BYTE_W-1:0]  byte_ff;
   logic               last_ff;
   logic [POS_W-1:0]   wi_ff, wi_in;
   logic [POS_W-1:0]   cs_ff, cs_in;
   logic [POS_W-1:0]   stack_ff [STACK_SLOTS];
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [SEEN_W-1:0]  seen_ff, seen_in;
   logic               invalid_ff, invalid_in;
   logic               ended_ff, ended_in;
   logic               dot0_ff, dot0_in;
   logic               dot1_ff, dot1_in;
   logic [SIZE_W-1:0]  size_ff;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   status_type         out_status_ff, out_status_in;
   logic               out_last_ff, out_last_in;

   logic [SEEN_W-1:0]  seen_inc;
   logic [POS_W-1:0]   comp_len;
   logic               is_dot, is_dotdot;
   logic [SLOT_W-1:0]  top_slot;
   logic [POS_W-1:0]   pop_val;
   logic [DEPTH_W-1:0] depth_dec;
   logic [SIZE_W-1:0]  eff_size;
   logic               out_load;
   logic               push_en;
   logic               ram_we;
   logic [BYTE_W-1:0]  ram_wr_data;
   logic [BYTE_W-1:0]  ram_rd_data;

   anp_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(PATH_BYTES)
   ) u_path_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wi_ff[IDX_W-1:0]),
      .wr_data(ram_wr_data),
      .rd_addr(rd_idx_in),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      seen_inc  = (seen_ff == SEEN_MAX) ? seen_ff : seen_ff + SEEN_W'(1);
      comp_len  = wi_ff - cs_ff;
      is_dot    = (comp_len == POS_W'(1)) && dot0_ff;
      is_dotdot = (comp_len == POS_W'(2)) && dot0_ff && dot1_ff;
      top_slot  = SLOT_W'(depth_ff - DEPTH_W'(1));
      pop_val   = (depth_ff == '0) ? POS_W'(1) : stack_ff[top_slot];
      depth_dec = (depth_ff == '0) ? depth_ff : depth_ff - DEPTH_W'(1);
      priority if (size_ff == '0) begin
         eff_size = SIZE_W'(1);
      end else if (size_ff > SIZE_W'(PATH_BYTES)) begin
         eff_size = SIZE_W'(PATH_BYTES);
      end else begin
         eff_size = size_ff;
      end
   end

   always_comb begin
      stat.active      = !invalid_ff && !ended_ff;
      stat.first       = (seen_ff == '0);
      stat.is_zero     = (byte_ff == CHAR_NUL);
      stat.is_slash    = (byte_ff == CHAR_SLASH);
      stat.full_after  = (seen_inc >= SEEN_W'(PATH_BYTES));
      stat.open_empty  = (wi_ff <= cs_ff);
      stat.pop2_needed = is_dotdot && (depth_ff >= DEPTH_W'(2));
      stat.last_beat   = last_ff;
      stat.fail        = invalid_ff || (seen_ff >= eff_size);
      stat.out_free    = !out_valid_ff || rsp_tready;
      stat.drain_last  = ((POS_W'(rd_idx_ff) + POS_W'(1)) == wi_ff);
   end

   always_comb begin
      wi_in         = wi_ff;
      cs_in         = cs_ff;
      depth_in      = depth_ff;
      seen_in       = seen_ff;
      invalid_in    = invalid_ff;
      ended_in      = ended_ff;
      dot0_in       = dot0_ff;
      dot1_in       = dot1_ff;
      rd_idx_in     = rd_idx_ff;
      push_en       = 1'b0;
      ram_we        = 1'b0;
      ram_wr_data   = byte_ff;
      out_load      = 1'b0;
      out_byte_in   = out_byte_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;

      if (cmd.first) begin
         if (byte_ff != CHAR_SLASH) begin
            invalid_in = 1'b1;
         end else begin
            seen_in = SEEN_W'(1);
         end
      end
      if (cmd.mark_end) begin
         ended_in = 1'b1;
      end
      if (cmd.count) begin
         seen_in = seen_inc;
      end
      if (cmd.open_comp) begin
         push_en  = (depth_ff < DEPTH_W'(STACK_SLOTS));
         depth_in = push_en ? depth_ff + DEPTH_W'(1) : depth_ff;
         if ((wi_ff > POS_W'(1)) && (wi_ff < POS_W'(PATH_BYTES))) begin
            ram_we      = 1'b1;
            ram_wr_data = CHAR_SLASH;
            wi_in       = wi_ff + POS_W'(1);
         end
         cs_in = wi_in;
      end
      if (cmd.put_char && (wi_ff < POS_W'(PATH_BYTES))) begin
         ram_we      = 1'b1;
         ram_wr_data = byte_ff;
         wi_in       = wi_ff + POS_W'(1);
         if (wi_ff == cs_ff) begin
            dot0_in = (byte_ff == CHAR_DOT);
         end
         if (wi_ff == cs_ff + POS_W'(1)) begin
            dot1_in = (byte_ff == CHAR_DOT);
         end
      end
      if (cmd.close) begin
         if (is_dot || is_dotdot) begin
            wi_in    = pop_val;
            depth_in = depth_dec;
            cs_in    = pop_val;
         end else begin
            cs_in = wi_ff;
         end
      end
      if (cmd.pop2) begin
         wi_in    = pop_val;
         depth_in = depth_dec;
         cs_in    = pop_val;
      end
      if (cmd.emit_error) begin
         out_load      = 1'b1;
         out_byte_in   = CHAR_NUL;
         out_status_in = invalid_ff ? STATUS_INVALID : STATUS_TOO_SMALL;
         out_last_in   = 1'b1;
      end
      if (cmd.drain_start) begin
         rd_idx_in = '0;
      end
      if (cmd.drain_step) begin
         out_load      = 1'b1;
         out_byte_in   = (rd_idx_ff == '0) ? CHAR_SLASH : ram_rd_data;
         out_status_in = STATUS_OK;
         out_last_in   = stat.drain_last;
         rd_idx_in     = rd_idx_ff + IDX_W'(1);
      end
      if (cmd.clear) begin
         wi_in      = POS_W'(1);
         cs_in      = POS_W'(1);
         depth_in   = '0;
         seen_in    = '0;
         invalid_in = 1'b0;
         ended_in   = 1'b0;
      end

      priority if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wi_ff        <= POS_W'(1);
         cs_ff        <= POS_W'(1);
         depth_ff     <= '0;
         seen_ff      <= '0;
         invalid_ff   <= 1'b0;
         ended_ff     <= 1'b0;
         size_ff      <= SIZE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         wi_ff        <= wi_in;
         cs_ff        <= cs_in;
         depth_ff     <= depth_in;
         seen_ff      <= seen_in;
         invalid_ff   <= invalid_in;
         ended_ff     <= ended_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         byte_ff <= req_tdata;
         last_ff <= req_tlast;
      end
      if (push_en) begin
         stack_ff[depth_ff[SLOT_W-1:0]] <= wi_ff;
      end
      dot0_ff       <= dot0_in;
      dot1_ff       <= dot1_in;
      rd_idx_ff     <= rd_idx_in;
      out_byte_ff   <= out_byte_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

[rtl/absolute_path_normalizer_top.sv]
// top level of the absolute path normaliser: controller, datapath and checks
//
// channel  dir  beat contents
// req      in   tdata[7:0] path_byte, tlast last_byte
// rsp      out  tdata[7:0] out_byte, tuser[1:0] status, tlast last_out
// csr      in   wr_data[6:0] capacity in bytes, taken whenever wr_en is high outside reset
//
// a req beat passes idle and byte, and also char when it opens a new component
// a slash or zero beat, or a flagged beat still building the path, adds a close step
// closing ".." with two or more open components adds a pop2 step for the second pop
// a flagged beat enters emit and drains the ram unless failed, one beat per cycle, up to 64
// rsp back-pressure holds the drain; req_tready stays low until the last rsp beat is loaded
// synchronous reset restores the capacity to 64 and an empty path, no clearing pass

`include "assert_macros.svh"

module absolute_path_normalizer_top
   import anp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // path_byte
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,   // out_byte
   output logic [1:0]        rsp_tuser,   // status
   output logic              rsp_tlast,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data
);

   dp_cmd_type  ctrl_cmd;
   dp_stat_type dp_stat;

   anp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   anp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .cmd        (ctrl_cmd),
      .stat       (dp_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `ASSERT_IMPLIES(a_no_req_mid_drain, rsp_tvalid && !rsp_tlast, !req_tready,
                   "req taken mid drain")
   `ASSERT_IMPLIES(a_error_beat_form, rsp_tvalid && (rsp_tuser != STATUS_OK),
                   rsp_tlast && (rsp_tdata == CHAR_NUL), "malformed error beat")
   `ASSERT_NEXT(a_error_emitted, ctrl_cmd.emit_error, rsp_tvalid && rsp_tlast,
                "error beat not presented")
   `ASSERT_IMPLIES(a_one_state_update, 1'b1,
                   $onehot0({ctrl_cmd.open_comp, ctrl_cmd.put_char, ctrl_cmd.close, ctrl_cmd.pop2}),
                   "conflicting path updates")

endmodule
